/* hdl/pidvr_pkg.sv */
// Shared types and constants for the PID voltage regulator.
// Holds the register map, the register bank struct and the default parameter values.
// No dependencies.
`timescale 1ns / 1ps

package pidvr_pkg;

  // Default sample and gain fraction widths
  localparam int SAMPLE_BITS_DEF    = 12;
  localparam int GAIN_FRAC_BITS_DEF = 12;

  // Fixed field widths
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DAC_W     = 12;
  localparam int DRIVE_W   = 16;
  localparam int TERM_W    = 16;
  localparam int ITERM_W   = 17;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INT_LIMIT = 3'd3,
    REG_OUT_LIMIT = 3'd4,
    REG_OUT_SCALE = 3'd5
  } cfg_reg_t;

  // Register bank contents
  typedef struct packed {
    logic [REG_W-1:0] gain_p;
    logic [REG_W-1:0] gain_i;
    logic [REG_W-1:0] gain_d;
    logic [REG_W-1:0] int_limit;
    logic [REG_W-1:0] out_limit;
    logic [REG_W-1:0] out_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:    16'd10240,
    gain_i:    16'd164,
    gain_d:    16'd1024,
    int_limit: 16'd5080,
    out_limit: 16'd5080,
    out_scale: 16'd52800
  };

endpackage

/* hdl/pidvr_cfg.sv */
// Configuration register bank for the PID voltage regulator.
// Depends on pidvr_pkg for the register map and the bank struct.
`timescale 1ns / 1ps

module pidvr_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pidvr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidvr_pkg::REG_W-1:0]         cfg_data,
  output pidvr_pkg::cfg_t                     cfg
);
  import pidvr_pkg::*;

  // Decode the index and update one register; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:    cfg.gain_p    <= cfg_data;
        REG_GAIN_I:    cfg.gain_i    <= cfg_data;
        REG_GAIN_D:    cfg.gain_d    <= cfg_data;
        REG_INT_LIMIT: cfg.int_limit <= cfg_data;
        REG_OUT_LIMIT: cfg.out_limit <= cfg_data;
        REG_OUT_SCALE: cfg.out_scale <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/pidvr_mul.sv */
// Shared signed-by-unsigned multiplier with a registered product.
// No package dependencies; widths come from the instantiating module.
`timescale 1ns / 1ps

module pidvr_mul #(
  parameter int AW = 29,
  parameter int BW = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic        [BW-1:0]    b,
  output logic signed [AW+BW-1:0] prod
);

  logic signed [AW+BW:0] full;

  // Treat b as a non-negative factor; the product always fits in AW+BW bits
  assign full = a * $signed({1'b0, b});

  // Hold the product until the sequencer asks for a new one
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[AW+BW-1:0];
    end
  end

endmodule

/* hdl/pid_voltage_regulator.sv */
// PID voltage regulator top level: sequencer, accumulator state and output register.
// Depends on pidvr_pkg, pidvr_cfg and pidvr_mul.
//
//   channel | signals                                      | beat
//   --------+----------------------------------------------+--------------------------
//   in      | in_valid, in_ready, setpoint, measured       | one feedback sample
//   out     | out_valid, out_ready, dac_code, drive,        | one regulator result
//           | p_term, i_term, d_term                        |
//   cfg     | cfg_we, cfg_index, cfg_data                   | one register write
//
// An input beat is taken in the idle state and then runs seven steps: the
// P, I, D and scale products go through the one shared multiplier, with the
// integral clamp, the sum and the drive clamp between them; an input beat
// waits for the idle state. Synchronous reset restores the register
// defaults and clears the integral and the stored error. A finished result
// sits in the output register while the next beat is taken; if it is still
// not taken when the next result is ready, the last step waits.
`timescale 1ns / 1ps

module pid_voltage_regulator #(
  parameter int SAMPLE_BITS    = pidvr_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = pidvr_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [SAMPLE_BITS-1:0]                 setpoint,
  input  logic [SAMPLE_BITS-1:0]                 measured,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [pidvr_pkg::DAC_W-1:0]            dac_code,
  output logic [pidvr_pkg::DRIVE_W-1:0]          drive,
  output logic signed [pidvr_pkg::TERM_W-1:0]    p_term,
  output logic signed [pidvr_pkg::ITERM_W-1:0]   i_term,
  output logic signed [pidvr_pkg::TERM_W-1:0]    d_term,
  input  logic                                   cfg_we,
  input  logic [pidvr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidvr_pkg::REG_W-1:0]            cfg_data
);
  import pidvr_pkg::*;

  localparam int EW  = SAMPLE_BITS + 1;            // error
  localparam int DW  = SAMPLE_BITS + 2;            // error difference
  localparam int AW  = REG_W + GAIN_FRAC_BITS + 1; // integral and multiplier operand
  localparam int PW  = AW + REG_W;                 // product
  localparam int DQW = REG_W + GAIN_FRAC_BITS;     // clamped drive in Q.F
  localparam int CW  = PW - GAIN_FRAC_BITS - REG_W;

  localparam logic [CW-1:0]        CODE_MAX    = CW'((1 << DAC_W) - 1);
  localparam logic signed [PW-1:0] FRAC_MASK_P = PW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
  localparam logic signed [AW-1:0] FRAC_MASK_A = AW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
  localparam logic signed [PW-1:0] SAT_MAX     = PW'(32767);
  localparam logic signed [PW-1:0] SAT_MIN     = PW'(-32768);

  typedef enum logic [2:0] {
    S_IDLE, S_P, S_I, S_D, S_SUM, S_CLAMP, S_SCALE, S_OUT
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic signed [EW-1:0]   err, err_in, last_error;
  logic signed [DW-1:0]   derr, derr_in;
  logic signed [AW-1:0]   integral, int_next, ilim;
  logic signed [PW-1:0]   p_q, d_q, prod;
  logic signed [PW:0]     pd, int_sum, ilim_x;
  logic signed [PW+1:0]   total, olim_x;
  logic [DQW-1:0]         drive_q, drive_next;
  logic signed [AW-1:0]   mul_a;
  logic [REG_W-1:0]       mul_b;
  logic                   mul_en;
  logic [CW-1:0]          code_full;
  logic [DAC_W-1:0]       code_sat;

  // Whole part toward zero, saturated to 16 bits
  function automatic logic signed [TERM_W-1:0] whole_sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] adj;
    logic signed [PW-1:0] w;
    adj = v[PW-1] ? v + FRAC_MASK_P : v;
    w   = adj >>> GAIN_FRAC_BITS;
    if (w > SAT_MAX) begin
      return SAT_MAX[TERM_W-1:0];
    end else if (w < SAT_MIN) begin
      return SAT_MIN[TERM_W-1:0];
    end
    return w[TERM_W-1:0];
  endfunction

  // Whole part of the clamped integral, toward zero
  function automatic logic signed [ITERM_W-1:0] whole_int(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] adj;
    logic signed [AW-1:0] w;
    adj = v[AW-1] ? v + FRAC_MASK_A : v;
    w   = adj >>> GAIN_FRAC_BITS;
    return w[ITERM_W-1:0];
  endfunction

  pidvr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidvr_mul #(
    .AW (AW),
    .BW (REG_W)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Error and error difference of the incoming beat
  assign err_in  = $signed({1'b0, setpoint}) - $signed({1'b0, measured});
  assign derr_in = $signed({last_error[EW-1], last_error}) - $signed({err_in[EW-1], err_in});

  // Feed the shared multiplier for the current step
  always_comb begin
    mul_en = 1'b1;
    unique case (state)
      S_P: begin
        mul_a = AW'(err);
        mul_b = cfg.gain_p;
      end
      S_I: begin
        mul_a = AW'(err);
        mul_b = cfg.gain_i;
      end
      S_D: begin
        mul_a = AW'(derr);
        mul_b = cfg.gain_d;
      end
      S_SCALE: begin
        mul_a = $signed({1'b0, drive_q});
        mul_b = cfg.out_scale;
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  // Clamp the integral to plus or minus its limit
  assign ilim    = $signed({1'b0, cfg.int_limit, {GAIN_FRAC_BITS{1'b0}}});
  assign ilim_x  = (PW+1)'(ilim);
  assign int_sum = (PW+1)'(integral) + (PW+1)'(prod);

  always_comb begin
    if (int_sum > ilim_x) begin
      int_next = ilim;
    end else if (int_sum < -ilim_x) begin
      int_next = -ilim;
    end else begin
      int_next = int_sum[AW-1:0];
    end
  end

  // Clamp the summed drive to zero .. output limit
  assign olim_x = $signed({{(PW+2-DQW){1'b0}}, cfg.out_limit, {GAIN_FRAC_BITS{1'b0}}});
  assign total  = (PW+2)'(pd) + (PW+2)'(integral);

  always_comb begin
    if (total[PW+1]) begin
      drive_next = '0;
    end else if (total > olim_x) begin
      drive_next = {cfg.out_limit, {GAIN_FRAC_BITS{1'b0}}};
    end else begin
      drive_next = total[DQW-1:0];
    end
  end

  // Scale product down to a DAC code and saturate
  assign code_full = prod[PW-1:GAIN_FRAC_BITS+REG_W];
  assign code_sat  = (code_full > CODE_MAX) ? {DAC_W{1'b1}} : code_full[DAC_W-1:0];

  assign in_ready = (state == S_IDLE);

  // Sequencer, accumulator state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      integral   <= '0;
      last_error <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            err        <= err_in;
            derr       <= derr_in;
            last_error <= err_in;
            state      <= S_P;
          end
        end
        S_P: begin
          state <= S_I;
        end
        S_I: begin
          p_q   <= prod;
          state <= S_D;
        end
        S_D: begin
          integral <= int_next;
          state    <= S_SUM;
        end
        S_SUM: begin
          d_q   <= prod;
          pd    <= (PW+1)'(p_q) + (PW+1)'(prod);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          drive_q <= drive_next;
          state   <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // Wait while the previous result is still held
          if (!out_valid || out_ready) begin
            dac_code  <= code_sat;
            drive     <= drive_q[DQW-1:GAIN_FRAC_BITS];
            p_term    <= whole_sat(p_q);
            i_term    <= whole_int(integral);
            d_term    <= whole_sat(d_q);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/pidvr_checker.sv */
// Port-level checks for the PID voltage regulator, bound to the top level.
// No package dependencies; sees only the top level's ports.
`timescale 1ns / 1ps

module pidvr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] dac_code,
  input logic [15:0] drive
);

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  // A taken beat starts the sequence, so the input side closes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after accepting a beat");

  // A new result only appears from a busy sequence
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work in progress");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(dac_code) && $stable(drive)))
    else $error("stalled result changed");

endmodule

bind pid_voltage_regulator pidvr_checker u_pidvr_checker (.*);

/* sim/pid_voltage_regulator_tb.sv */
// Self-checking testbench for the PID voltage regulator: directed samples, then random phases.
// A local predictor tracks the integral and the last error; results are checked beat by beat.
// Depends on pidvr_pkg and pid_voltage_regulator.
`timescale 1ns / 1ps

module pid_voltage_regulator_tb;
  import pidvr_pkg::*;

  localparam int SB            = SAMPLE_BITS_DEF;
  localparam int FRAC          = GAIN_FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_SAMPLES = 100;

  // Indexes past the register map; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [SB-1:0]        FULL_SCALE  = '1;

  typedef struct packed {
    logic [DAC_W-1:0]   dac_code;
    logic [DRIVE_W-1:0] drive;
    logic [TERM_W-1:0]  p_term;
    logic [ITERM_W-1:0] i_term;
    logic [TERM_W-1:0]  d_term;
  } pid_result_t;

  typedef struct packed {
    logic [SB-1:0] sp;
    logic [SB-1:0] ms;
    logic          typed;
    pid_result_t   res;
  } sample_row_t;

  localparam pid_result_t NO_RESULT     = '0;
  localparam int          DIRECTED_ROWS = 16;

  // Directed samples at reset gains; typed rows hold results worked out by hand
  localparam sample_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{12'd0,    12'd0,    1'b1, '{12'd0, 16'd0, 16'd0, 17'd0, 16'd0}},
    // full positive error: drive clamps at the output limit
    '{12'd4095, 12'd0,    1'b1, '{12'd4092, 16'd5080, 16'd10237, 17'd163, -16'sd1023}},
    // full negative error: integral returns to zero, drive clamps at zero
    '{12'd0,    12'd4095, 1'b1, '{12'd0, 16'd0, -16'sd10237, 17'd0, 16'd2047}},
    '{12'd4095, 12'd4095, 1'b0, NO_RESULT},
    '{12'd2048, 12'd2047, 1'b0, NO_RESULT},
    '{12'd2047, 12'd2048, 1'b0, NO_RESULT},
    '{12'd1,    12'd0,    1'b0, NO_RESULT},
    '{12'd0,    12'd1,    1'b0, NO_RESULT},
    '{12'd4095, 12'd4094, 1'b0, NO_RESULT},
    '{12'd1234, 12'd567,  1'b0, NO_RESULT},
    '{12'd567,  12'd1234, 1'b0, NO_RESULT},
    '{12'd3000, 12'd100,  1'b0, NO_RESULT},
    '{12'd100,  12'd3000, 1'b0, NO_RESULT},
    '{12'd2730, 12'd1365, 1'b0, NO_RESULT},
    '{12'd1365, 12'd2730, 1'b0, NO_RESULT},
    '{12'd4095, 12'd0,    1'b0, NO_RESULT}
  };

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic [SB-1:0]              setpoint  = '0;
  logic [SB-1:0]              measured  = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [DAC_W-1:0]           dac_code;
  logic [DRIVE_W-1:0]         drive;
  logic signed [TERM_W-1:0]   p_term;
  logic signed [ITERM_W-1:0]  i_term;
  logic signed [TERM_W-1:0]   d_term;
  logic                       cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [REG_W-1:0]           cfg_data  = '0;

  // Predictor state: register shadow, integral in Q.FRAC, previous error
  cfg_t        shadow   = CFG_RESET;
  longint      integ_q  = 0;
  longint      prev_err = 0;
  pid_result_t regulator_outputs_due [$];

  int          in_beats    = 0;
  int          fail_count  = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = 11;
  int          rx_idle_pct = 47;
  logic        row_typed   = 1'b0;
  pid_result_t row_result  = '0;

  pid_voltage_regulator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .setpoint  (setpoint),
    .measured  (measured),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dac_code  (dac_code),
    .drive     (drive),
    .p_term    (p_term),
    .i_term    (i_term),
    .d_term    (d_term),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint whole_toward_zero(input longint v);
    if (v >= 0) return v >>> FRAC;
    return -((-v) >>> FRAC);
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Advance the regulator by one sample and return the result it should report
  function automatic pid_result_t regulate(input logic [SB-1:0] sp, input logic [SB-1:0] ms);
    longint      err, prop, deriv, ilim, olim, total, code;
    pid_result_t r;
    err   = longint'(sp) - longint'(ms);
    prop  = longint'(shadow.gain_p) * err;
    deriv = longint'(shadow.gain_d) * (prev_err - err);
    ilim  = longint'(shadow.int_limit) <<< FRAC;
    olim  = longint'(shadow.out_limit) <<< FRAC;
    integ_q += longint'(shadow.gain_i) * err;
    if (integ_q > ilim) integ_q = ilim;
    if (integ_q < -ilim) integ_q = -ilim;
    prev_err = err;
    // Sum the unsaturated terms, then clamp to 0..output_limit
    total = prop + integ_q + deriv;
    if (total > olim) total = olim;
    if (total < 0) total = 0;
    code = (total * longint'(shadow.out_scale)) >>> (FRAC + 16);
    if (code > 4095) code = 4095;
    r.dac_code = DAC_W'(code);
    r.drive    = DRIVE_W'(total >>> FRAC);
    r.p_term   = TERM_W'(clip16(whole_toward_zero(prop)));
    r.i_term   = ITERM_W'(whole_toward_zero(integ_q));
    r.d_term   = TERM_W'(clip16(whole_toward_zero(deriv)));
    return r;
  endfunction

  function automatic logic [REG_W-1:0] random_reg();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return REG_W'($urandom_range(0, 4095));
      default: return REG_W'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.gain_p    = random_reg();
    c.gain_i    = random_reg();
    c.gain_d    = random_reg();
    c.int_limit = random_reg();
    c.out_limit = random_reg();
    c.out_scale = random_reg();
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Offer one sample beat, with random idle cycles ahead of it; return once taken
  task automatic send_sample(input logic [SB-1:0] sp, input logic [SB-1:0] ms,
                             input logic typed, input pid_result_t res);
    int taken;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    taken = in_beats;
    in_valid   <= 1'b1;
    setpoint   <= sp;
    measured   <= ms;
    row_typed  <= typed;
    row_result <= res;
    do @(negedge clk); while (in_beats == taken);
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (regulator_outputs_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all six registers back to back, then poke the unused indexes
  task automatic load_config(input cfg_t c);
    cfg_reg_t         order [6];
    logic [REG_W-1:0] vals [6];
    order = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_INT_LIMIT, REG_OUT_LIMIT, REG_OUT_SCALE};
    vals  = '{c.gain_p, c.gain_i, c.gain_d, c.int_limit, c.out_limit, c.out_scale};
    for (int k = 0; k < 6; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= vals[k];
      @(negedge clk);
    end
    cfg_index <= REG_SPARE_A;
    cfg_data  <= REG_W'($urandom);
    @(negedge clk);
    cfg_index <= REG_SPARE_B;
    cfg_data  <= REG_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow = c;
  endtask

  // Check result beats against the oldest expectation, predict on sample beats
  always @(posedge clk) begin
    pid_result_t want, predicted;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (regulator_outputs_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding, drive %0d", drive));
        end else begin
          want = regulator_outputs_due.pop_front();
          if (dac_code !== want.dac_code)
            report_mismatch($sformatf("dac_code got %0d want %0d", dac_code, want.dac_code));
          if (drive !== want.drive)
            report_mismatch($sformatf("drive got %0d want %0d", drive, want.drive));
          if (p_term !== want.p_term)
            report_mismatch($sformatf("p_term got %0d want %0d", p_term, $signed(want.p_term)));
          if (i_term !== want.i_term)
            report_mismatch($sformatf("i_term got %0d want %0d", i_term, $signed(want.i_term)));
          if (d_term !== want.d_term)
            report_mismatch($sformatf("d_term got %0d want %0d", d_term, $signed(want.d_term)));
        end
      end
      if (in_valid && in_ready) begin
        predicted = regulate(setpoint, measured);
        regulator_outputs_due.push_back(row_typed ? row_result : predicted);
        in_beats++;
      end
    end
  end

  // Stall the result channel at the current rate
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, regulator_outputs_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int            m;
    logic [SB-1:0] sp, ms, hold_sp;
    cfg_t          c;
    hold_sp = SB'($urandom);
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_sample(DIRECTED[r].sp, DIRECTED[r].ms, DIRECTED[r].typed, DIRECTED[r].res);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // Reprogram only once the block is empty
      if (ph > 0) begin
        drain();
        case (ph)
          1: load_config('1);
          2: begin
            c = random_config();
            c.int_limit = '0;
            c.out_limit = '0;
            load_config(c);
          end
          3: load_config('0);
          8: load_config(CFG_RESET);
          default: load_config(random_config());
        endcase
      end
      case (ph / 3)
        0: begin tx_idle_pct = 11; rx_idle_pct = 47; end
        1: begin tx_idle_pct = 47; rx_idle_pct = 11; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase

      for (int k = 0; k < PHASE_SAMPLES; k++) begin
        if (k == PHASE_SAMPLES / 2 && ph % 2 == 0) drain();
        case ($urandom_range(0, 9))
          // Regulation: measured hovers around a setpoint that moves now and then
          0, 1, 2, 3, 4, 5: begin
            if ($urandom_range(0, 15) == 0) hold_sp = SB'($urandom);
            sp = hold_sp;
            m  = int'(hold_sp) + int'($urandom_range(0, 128)) - 64;
            if (m < 0) m = 0;
            if (m > int'(FULL_SCALE)) m = int'(FULL_SCALE);
            ms = SB'(m);
          end
          6, 7, 8: begin
            sp = SB'($urandom);
            ms = SB'($urandom);
          end
          default: begin
            sp = $urandom_range(0, 1) ? FULL_SCALE : '0;
            ms = $urandom_range(0, 1) ? FULL_SCALE : '0;
          end
        endcase
        send_sample(sp, ms, 1'b0, NO_RESULT);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
